// File: hw/rtl/tcc_pkg.sv
// Shared types and constants for the text console cursor block.
// Used by tcc_cursor_step and text_console_cursor_core; no dependencies.
package tcc_pkg;

    localparam int COORD_W = 12;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 24;

    // Glyph cell size in pixels; both must be powers of two.
    localparam int GLYPH_WIDTH  = 8;
    localparam int GLYPH_HEIGHT = 16;

    localparam logic [COORD_W-1:0] RESET_WIDTH    = 12'd1024;
    localparam logic [COORD_W-1:0] RESET_HEIGHT   = 12'd768;
    localparam logic [COORD_W-1:0] RESET_CURSOR_Y = RESET_HEIGHT - COORD_W'(GLYPH_HEIGHT);

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

    // Configuration register indexes.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_DRAW       = 3'd1,
        OP_CLEAR_CELL = 3'd2,
        OP_SCROLL     = 3'd3,
        OP_CLEAR_LINE = 3'd4
    } op_t;

    // Everything one character produces: an optional cell command, then an
    // optional scroll followed by a line clear.
    typedef struct packed {
        logic                 has_cell;
        op_t                  cell_op;
        logic [COORD_W-1:0]   cell_x;
        logic [COORD_W-1:0]   cell_y;
        logic [CHAR_W-1:0]    code;
        logic [COLOR_W-1:0]   color;
        logic                 scroll;
        logic [COORD_W-1:0]   line_y;
        logic                 drew;
    } bundle_t;

endpackage

// File: hw/rtl/text_console_cursor_core.sv
// Top level of the text console cursor: stream ports, configuration
// registers, cursor state and command sequencing. Depends on tcc_pkg and
// tcc_cursor_step.
//
// Usage: one character per transfer arrives on the s_axis channel. For each
// character the block emits one to three renderer commands on the m_axis
// channel, one per cycle: an optional draw-glyph or clear-cell command,
// then, when the cursor runs off the bottom, a scroll and a clear of the
// bottom text line. A character that causes nothing yields one command with
// op none. tlast marks the final command of each character.
// Path: a character passes through the input register and the bundle
// register before its first command reaches the output register.
// Throughput: one command per cycle while m_axis_tready is high, set by
// the single output register. Input is registered, the cursor update is
// one combinational pass into a command bundle register, and the bundle is
// unloaded into the output register, so a new character is taken while the
// previous one's commands are still leaving.
// Reset: the screen is 1024 by 768 pixels and the cursor sits at column
// zero of the bottom text line; no commands are pending.
// Stall: when m_axis_tready is low the output register holds, the bundle
// and input registers fill, and s_axis_tready drops until space frees.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while idle (not enforced).
module text_console_cursor_core (
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration write port: index 0 width, index 1 height.
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [tcc_pkg::COORD_W-1:0]  cfg_data,
    // Input stream.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,  // char_code[7:0], fg_color[31:8]
    // Command stream.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [55:0]                  m_axis_tdata,  // pos_x[11:0], pos_y[23:12],
                                                        // glyph_code[31:24], glyph_color[55:32]
    output logic [3:0]                   m_axis_tuser,  // op[2:0], drawn[3]
    output logic                         m_axis_tlast
);
    import tcc_pkg::*;

    // Configuration registers.
    logic [COORD_W-1:0] width_reg;
    logic [COORD_W-1:0] height_reg;

    // Cursor state.
    logic [COORD_W-1:0] cursor_x_reg;
    logic [COORD_W-1:0] cursor_y_reg;
    logic [COORD_W-1:0] cursor_x_next;
    logic [COORD_W-1:0] cursor_y_next;

    // Input register.
    logic               in_valid_reg;
    logic [CHAR_W-1:0]  in_char_reg;
    logic [COLOR_W-1:0] in_color_reg;

    // Command bundle for the character being emitted.
    logic               bnd_valid_reg;
    bundle_t            bnd_reg;
    bundle_t            bnd_next;
    logic [1:0]         idx_reg;

    // Output register.
    logic               out_valid_reg;
    op_t                out_op_reg;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic [CHAR_W-1:0]  out_code_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_drawn_reg;
    logic               out_last_reg;

    // Current command selected from the bundle.
    logic [1:0]         slot;
    op_t                cur_op;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [CHAR_W-1:0]  cur_code;
    logic [COLOR_W-1:0] cur_color;
    logic               cur_last;

    logic out_load;
    logic bnd_free;
    logic take_item;
    logic in_xfer;

    tcc_cursor_step u_step (
        .cursor_x         (cursor_x_reg),
        .cursor_y         (cursor_y_reg),
        .screen_width_px  (width_reg),
        .screen_height_px (height_reg),
        .char_code        (in_char_reg),
        .fg_color         (in_color_reg),
        .cursor_x_next    (cursor_x_next),
        .cursor_y_next    (cursor_y_next),
        .bundle           (bnd_next)
    );

    // Slot 0 is the cell command, slot 1 the scroll, slot 2 the line clear.
    // Without a cell command the sequence starts at slot 1; a character with
    // neither yields op none there.
    always_comb
    begin
        slot      = bnd_reg.has_cell ? idx_reg : (idx_reg + 2'd1);
        cur_op    = OP_NONE;
        cur_x     = '0;
        cur_y     = '0;
        cur_code  = '0;
        cur_color = '0;
        case (slot)
            2'd0:
            begin
                cur_op    = bnd_reg.cell_op;
                cur_x     = bnd_reg.cell_x;
                cur_y     = bnd_reg.cell_y;
                cur_code  = bnd_reg.code;
                cur_color = bnd_reg.color;
            end
            2'd1:
            begin
                cur_op = bnd_reg.scroll ? OP_SCROLL : OP_NONE;
            end
            2'd2:
            begin
                cur_op = OP_CLEAR_LINE;
                cur_y  = bnd_reg.line_y;
            end
            default:
            begin
                cur_op = OP_NONE;
            end
        endcase
        cur_last = bnd_reg.scroll ? (slot == 2'd2) : 1'b1;
    end

    assign out_load      = bnd_valid_reg && (!out_valid_reg || m_axis_tready);
    assign bnd_free      = out_load && cur_last;
    assign take_item     = in_valid_reg && (!bnd_valid_reg || bnd_free);
    assign s_axis_tready = !in_valid_reg || take_item;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else
            begin
                height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (take_item)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_char_reg  <= s_axis_tdata[CHAR_W-1:0];
            in_color_reg <= s_axis_tdata[CHAR_W+COLOR_W-1:CHAR_W];
        end
    end

    // The cursor advances when a character moves into the bundle register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg  <= '0;
            cursor_y_reg  <= RESET_CURSOR_Y;
            bnd_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (take_item)
        begin
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            bnd_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (bnd_free)
        begin
            bnd_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            bnd_reg <= bnd_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_op_reg    <= cur_op;
            out_x_reg     <= cur_x;
            out_y_reg     <= cur_y;
            out_code_reg  <= cur_code;
            out_color_reg <= cur_color;
            out_drawn_reg <= bnd_reg.drew;
            out_last_reg  <= cur_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_color_reg, out_code_reg, out_y_reg, out_x_reg};
    assign m_axis_tuser  = {out_drawn_reg, out_op_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: hw/rtl/tcc_cursor_step.sv
// Combinational cursor update for one character: next cursor and the
// command bundle. Depends on tcc_pkg.
module tcc_cursor_step (
    input  logic [tcc_pkg::COORD_W-1:0] cursor_x,
    input  logic [tcc_pkg::COORD_W-1:0] cursor_y,
    input  logic [tcc_pkg::COORD_W-1:0] screen_width_px,
    input  logic [tcc_pkg::COORD_W-1:0] screen_height_px,
    input  logic [tcc_pkg::CHAR_W-1:0]  char_code,
    input  logic [tcc_pkg::COLOR_W-1:0] fg_color,
    output logic [tcc_pkg::COORD_W-1:0] cursor_x_next,
    output logic [tcc_pkg::COORD_W-1:0] cursor_y_next,
    output tcc_pkg::bundle_t            bundle
);
    import tcc_pkg::*;

    localparam int WIDE_W = COORD_W + 1;
    localparam logic [WIDE_W-1:0] GW = WIDE_W'(GLYPH_WIDTH);
    localparam logic [WIDE_W-1:0] GH = WIDE_W'(GLYPH_HEIGHT);

    logic [WIDE_W-1:0] x_w;
    logic [WIDE_W-1:0] y_w;
    logic [WIDE_W-1:0] back_x;
    logic [WIDE_W-1:0] width_w;
    logic [WIDE_W-1:0] height_w;
    logic [WIDE_W-1:0] round_x;
    logic [WIDE_W-1:0] round_y;

    always_comb
    begin
        width_w  = {1'b0, screen_width_px};
        height_w = {1'b0, screen_height_px};
        x_w      = {1'b0, cursor_x};
        y_w      = {1'b0, cursor_y};
        back_x   = x_w;
        round_x  = (x_w + GW - WIDE_W'(1)) & ~(GW - WIDE_W'(1));
        round_y  = (y_w + GH - WIDE_W'(1)) & ~(GH - WIDE_W'(1));
        bundle   = '0;
        bundle.cell_op = OP_NONE;

        // Characters are only interpreted while the cursor is on screen.
        if ((x_w < width_w) && (y_w < height_w))
        begin
            if (char_code == CH_NEWLINE)
            begin
                x_w = '0;
                y_w = y_w + GH;
            end
            else if (char_code == CH_BACKSPACE)
            begin
                if ((cursor_x != '0) || (cursor_y != '0))
                begin
                    if (cursor_x == '0)
                    begin
                        y_w    = (y_w >= GH) ? (y_w - GH) : '0;
                        back_x = width_w;
                    end
                    x_w = (back_x >= GW) ? (back_x - GW) : '0;
                    bundle.has_cell = 1'b1;
                    bundle.cell_op  = OP_CLEAR_CELL;
                    bundle.cell_x   = x_w[COORD_W-1:0];
                    bundle.cell_y   = y_w[COORD_W-1:0];
                end
            end
            else
            begin
                bundle.has_cell = 1'b1;
                bundle.cell_op  = OP_DRAW;
                bundle.cell_x   = round_x[COORD_W-1:0];
                bundle.cell_y   = round_y[COORD_W-1:0];
                bundle.code     = char_code;
                bundle.color    = fg_color;
                bundle.drew     = 1'b1;
                x_w = x_w + GW;
            end
        end

        // Wrap at the right edge, then scroll at the bottom.
        if (x_w >= width_w)
        begin
            x_w = '0;
            y_w = y_w + GH;
        end
        if (y_w >= height_w)
        begin
            y_w = (height_w >= GH) ? (height_w - GH) : '0;
            bundle.scroll = 1'b1;
            bundle.line_y = y_w[COORD_W-1:0];
        end

        cursor_x_next = x_w[COORD_W-1:0];
        cursor_y_next = y_w[COORD_W-1:0];
    end

endmodule
